// ----- sv/ogsf_pkg.sv -----
package ogsf_pkg;

  localparam int MAX_WIDTH_DEF     = 64;
  localparam int MAX_HEIGHT_DEF    = 64;
  localparam int OBSTACLE_SIZE_DEF = 2;

  // Grid register file
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  localparam logic [6:0] GRID_WIDTH_RST  = 7'd64;
  localparam logic [6:0] GRID_HEIGHT_RST = 7'd64;

  // Obstacle marking: low cells jump to the floor, others count up and saturate
  localparam logic [7:0] OBST_FLOOR = 8'd2;
  localparam logic [7:0] CELL_MAX   = 8'hFF;

  typedef enum logic [1:0] {
    FUNC_READ     = 2'd0,
    FUNC_WRITE    = 2'd1,
    FUNC_OBSTACLE = 2'd2,
    FUNC_QUERY    = 2'd3
  } func_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_value;
    logic [6:0] square_size;
    logic [5:0] center_row;
    logic [5:0] center_col;
  } out_item_t;

endpackage

// ----- sv/ogsf_ram.sv -----
module ogsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/ogsf_cell_unit.sv -----
module ogsf_cell_unit #(
  parameter int SZW = 7
) (
  input  logic [7:0]     cell_value,
  input  logic [SZW-1:0] up,
  input  logic [SZW-1:0] left,
  input  logic [SZW-1:0] diag,
  input  logic           edge_cell,
  input  logic [SZW-1:0] best,
  output logic [7:0]     cell_raised,
  output logic [SZW-1:0] score,
  output logic           better
);

  import ogsf_pkg::*;

  logic [SZW-1:0] least;

  always_comb begin
    if (cell_value < OBST_FLOOR) begin
      cell_raised = OBST_FLOOR;
    end else if (cell_value == CELL_MAX) begin
      cell_raised = CELL_MAX;
    end else begin
      cell_raised = cell_value + 8'd1;
    end
  end

  always_comb begin
    least = left;
    if (up < least) begin
      least = up;
    end
    if (diag < least) begin
      least = diag;
    end
  end

  always_comb begin
    priority if (cell_value != 8'd0) begin
      score = '0;
    end else if (edge_cell) begin
      score = SZW'(1);
    end else begin
      score = least + SZW'(1);
    end
  end

  assign better = score > best;

endmodule

// ----- sv/occupancy_grid_square_finder.sv -----
// Occupancy grid with largest-empty-square search.
// Input channel (in_valid/in_ready/in_data) carries one operation per transfer:
// read, write, obstacle marking or empty-square query. Output channel
// (out_valid/out_ready/out_data) returns exactly one result per operation,
// in order. Grid size registers must be written through cfg_we/cfg_index/cfg_data
// by the user only while no operation is in flight; the block does not check it.
// One operation is processed at a time; in_ready is high only when idle.
// An obstacle operation does one cell RAM read per cell of the OBSTACLE_SIZE^2
// block and one write per cell inside the grid; a query does one cell RAM read
// plus one score step per cell of the h x w grid in use.
// After reset the cell RAM is swept to zero, one entry per cycle, over all
// 2^(clog2(MAX_HEIGHT)+clog2(MAX_WIDTH)) entries (4096 by default); in_ready
// stays low during the sweep, configuration writes are taken as usual.
// The result sits in an output register; when the receiver stalls, a finished
// operation waits for the register to free up and the block takes no new item.
module occupancy_grid_square_finder #(
  parameter int MAX_WIDTH     = ogsf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT    = ogsf_pkg::MAX_HEIGHT_DEF,
  parameter int OBSTACLE_SIZE = ogsf_pkg::OBSTACLE_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ogsf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ogsf_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_data
);

  import ogsf_pkg::*;

  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int MIND  = (MAX_WIDTH < MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SZW   = $clog2(MIND + 1);
  localparam int DW    = 9;
  localparam int OKW   = (OBSTACLE_SIZE > 1) ? $clog2(OBSTACLE_SIZE) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_RREQ, S_RDAT, S_ORD, S_OWR,
    S_QSTART, S_QRD, S_QCALC, S_QFIN, S_DONE
  } state_t;

  state_t      state;
  in_item_t    item;
  out_item_t   res;
  logic [6:0]  grid_width;
  logic [6:0]  grid_height;
  logic [AW-1:0] clr_cnt;
  logic [OKW-1:0] ok;
  logic [OKW-1:0] ol;
  logic [DW-1:0] qi;
  logic [DW-1:0] qj;
  logic [SZW-1:0] left;
  logic [SZW-1:0] diag;
  logic [SZW-1:0] best;
  logic [DW-1:0] bi;
  logic [DW-1:0] bj;

  logic [DW-1:0] uw;
  logic [DW-1:0] uh;
  logic          rw_in;
  logic [DW-1:0] orow;
  logic [DW-1:0] ocol;
  logic          obst_in;
  logic          obst_last;
  logic [DW-1:0] half;
  logic [DW-1:0] crow;
  logic [DW-1:0] ccol;

  logic          cell_we;
  logic [AW-1:0] cell_waddr;
  logic [7:0]    cell_wdata;
  logic [AW-1:0] cell_raddr;
  logic [7:0]    cell_rdata;
  logic [SZW-1:0] prev_rdata;
  logic [SZW-1:0] up;
  logic          edge_cell;
  logic [7:0]    cell_raised;
  logic [SZW-1:0] score;
  logic          better;

  function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] r, input logic [DW-1:0] c);
    cell_addr = {r[RW-1:0], c[CW-1:0]};
  endfunction

  assign uw = (DW'(grid_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(grid_width);
  assign uh = (DW'(grid_height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(grid_height);

  assign rw_in     = (DW'(item.row) < uh) && (DW'(item.col) < uw);
  assign orow      = DW'(item.row) + DW'(ok);
  assign ocol      = DW'(item.col) + DW'(ol);
  assign obst_in   = (orow < uh) && (ocol < uw);
  assign obst_last = (ok == OKW'(OBSTACLE_SIZE - 1)) && (ol == OKW'(OBSTACLE_SIZE - 1));

  assign half = DW'(best >> 1);
  assign crow = bi - half;
  assign ccol = bj - half;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = cell_addr(orow, ocol);
    cell_wdata = cell_raised;
    cell_raddr = cell_addr(qi, qj);
    unique case (state)
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_cnt;
        cell_wdata = 8'd0;
      end
      S_WRITE: begin
        cell_we    = rw_in;
        cell_waddr = cell_addr(DW'(item.row), DW'(item.col));
        cell_wdata = item.write_value;
      end
      S_RREQ: cell_raddr = cell_addr(DW'(item.row), DW'(item.col));
      S_ORD:  cell_raddr = cell_addr(orow, ocol);
      S_OWR:  cell_we    = obst_in;
      default: ;
    endcase
  end

  assign up        = (qi == '0) ? '0 : prev_rdata;
  assign edge_cell = (qi == '0) || (qj == '0);

  ogsf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  ogsf_ram #(
    .WIDTH (SZW),
    .DEPTH (1 << CW)
  ) u_prev_row (
    .clk   (clk),
    .we    (state == S_QCALC),
    .waddr (qj[CW-1:0]),
    .wdata (score),
    .raddr (qj[CW-1:0]),
    .rdata (prev_rdata)
  );

  ogsf_cell_unit #(
    .SZW (SZW)
  ) u_cell_unit (
    .cell_value  (cell_rdata),
    .up          (up),
    .left        (left),
    .diag        (diag),
    .edge_cell   (edge_cell),
    .best        (best),
    .cell_raised (cell_raised),
    .score       (score),
    .better      (better)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            res  <= '0;
            ok   <= '0;
            ol   <= '0;
            unique case (in_data.func)
              FUNC_READ:     state <= S_RREQ;
              FUNC_WRITE:    state <= S_WRITE;
              FUNC_OBSTACLE: state <= S_ORD;
              FUNC_QUERY:    state <= S_QSTART;
              default:       state <= S_IDLE;
            endcase
          end
        end
        S_WRITE: begin
          res.status <= !rw_in;
          state      <= S_DONE;
        end
        S_RREQ: begin
          if (rw_in) begin
            state <= S_RDAT;
          end else begin
            res.status <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_RDAT: begin
          res.read_value <= cell_rdata;
          state          <= S_DONE;
        end
        S_ORD: state <= S_OWR;
        S_OWR: begin
          // advance through the obstacle block row-major
          if (obst_last) begin
            state <= S_DONE;
          end else begin
            if (ol == OKW'(OBSTACLE_SIZE - 1)) begin
              ol <= '0;
              ok <= ok + OKW'(1);
            end else begin
              ol <= ol + OKW'(1);
            end
            state <= S_ORD;
          end
        end
        S_QSTART: begin
          qi   <= '0;
          qj   <= '0;
          left <= '0;
          diag <= '0;
          best <= '0;
          bi   <= '0;
          bj   <= '0;
          if (uw == '0 || uh == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_QRD;
          end
        end
        S_QRD: state <= S_QCALC;
        S_QCALC: begin
          if (better) begin
            best <= score;
            bi   <= qi;
            bj   <= qj;
          end
          if (qj + DW'(1) == uw) begin
            qj   <= '0;
            left <= '0;
            diag <= '0;
            qi   <= qi + DW'(1);
            if (qi + DW'(1) == uh) begin
              state <= S_QFIN;
            end else begin
              state <= S_QRD;
            end
          end else begin
            qj    <= qj + DW'(1);
            left  <= score;
            diag  <= up;
            state <= S_QRD;
          end
        end
        S_QFIN: begin
          res.square_size <= 7'(best);
          res.center_row  <= crow[5:0];
          res.center_col  <= ccol[5:0];
          state           <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new item taken while one is in flight");

  a_best_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_QCALC && better) |=> (best > $past(best)))
    else $error("best square size did not grow on a new maximum");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |->
      (out_data.read_value == 8'd0 && out_data.square_size == 7'd0))
    else $error("out-of-bounds result carries data");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside completion");

endmodule

// ----- test/tb_occupancy_grid_square_finder.sv -----
module tb_occupancy_grid_square_finder;
  import ogsf_pkg::*;

  localparam int GRID_MAX_W  = MAX_WIDTH_DEF;
  localparam int GRID_MAX_H  = MAX_HEIGHT_DEF;
  localparam int BLOCK_SIDE  = OBSTACLE_SIZE_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int NUM_PHASES  = 9;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic       cfg_index = CFG_GRID_WIDTH;
  logic [6:0] cfg_data = '0;

  // Shadow of the grid and of the size registers
  logic [7:0] grid_cells [GRID_MAX_W*GRID_MAX_H];
  logic [6:0] shadow_width = GRID_WIDTH_RST;
  logic [6:0] shadow_height = GRID_HEIGHT_RST;

  in_item_t  op_queue [$];
  out_item_t awaited_results [$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycle_count = 0;

  occupancy_grid_square_finder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to the shadow grid and return the result it gives
  function automatic out_item_t grid_op_result(input in_item_t op);
    out_item_t  res;
    int         w, h, r, c, k, l;
    int         s, up, left, diag, best, best_r, best_c;
    int         prev_sizes [GRID_MAX_W];
    logic [7:0] v;
    res = '0;
    w = (shadow_width > GRID_MAX_W) ? GRID_MAX_W : int'(shadow_width);
    h = (shadow_height > GRID_MAX_H) ? GRID_MAX_H : int'(shadow_height);
    r = int'(op.row);
    c = int'(op.col);
    case (op.func)
      FUNC_READ: begin
        if (r < h && c < w) res.read_value = grid_cells[r*GRID_MAX_W + c];
        else res.status = 1'b1;
      end
      FUNC_WRITE: begin
        if (r < h && c < w) grid_cells[r*GRID_MAX_W + c] = op.write_value;
        else res.status = 1'b1;
      end
      FUNC_OBSTACLE: begin
        for (k = 0; k < BLOCK_SIDE; k++) begin
          for (l = 0; l < BLOCK_SIDE; l++) begin
            if (r + k < h && c + l < w) begin
              v = grid_cells[(r+k)*GRID_MAX_W + c + l];
              if (v < OBST_FLOOR) v = OBST_FLOOR;
              else if (v != CELL_MAX) v = v + 8'd1;
              grid_cells[(r+k)*GRID_MAX_W + c + l] = v;
            end
          end
        end
      end
      default: begin
        best = 0;
        best_r = 0;
        best_c = 0;
        for (r = 0; r < h; r++) begin
          left = 0;
          diag = 0;
          for (c = 0; c < w; c++) begin
            up = (r == 0) ? 0 : prev_sizes[c];
            if (grid_cells[r*GRID_MAX_W + c] != 0) begin
              s = 0;
            end else if (r == 0 || c == 0) begin
              s = 1;
            end else begin
              s = left;
              if (up < s) s = up;
              if (diag < s) s = diag;
              s = s + 1;
            end
            diag = up;
            prev_sizes[c] = s;
            left = s;
            // keep the first strict maximum in row-major order
            if (s > best) begin
              best = s;
              best_r = r;
              best_c = c;
            end
          end
        end
        res.square_size = 7'(best);
        res.center_row = 6'(best_r - best / 2);
        res.center_col = 6'(best_c - best / 2);
      end
    endcase
    return res;
  endfunction

  function automatic logic [7:0] pick_coord(input int dim);
    if ($urandom_range(99) < 85) return 8'($urandom_range(dim));
    return 8'($urandom_range(255));
  endfunction

  function automatic in_item_t random_op(input int w, input int h, input int query_pct,
                                         input bit force_query);
    in_item_t op;
    int       pick;
    op.row = pick_coord(h);
    op.col = pick_coord(w);
    op.write_value = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (force_query || pick < query_pct) begin
      op.func = FUNC_QUERY;
    end else begin
      pick = $urandom_range(99);
      if (pick < 30) op.func = FUNC_READ;
      else if (pick < 80) op.func = FUNC_WRITE;
      else op.func = FUNC_OBSTACLE;
    end
    return op;
  endfunction

  task automatic push_op(input func_t f, input int r, input int c, input int val);
    in_item_t op;
    op.func = f;
    op.row = 8'(r);
    op.col = 8'(c);
    op.write_value = 8'(val);
    op_queue.push_back(op);
  endtask

  // Hold until every queued item has been taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (op_queue.size() != 0 || in_valid || awaited_results.size() != 0);
  endtask

  task automatic set_grid_dims(input logic [6:0] w, input logic [6:0] h);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GRID_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_GRID_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_width = w;
    shadow_height = h;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Driver: advance to the next queued item once the current one transfers
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) awaited_results.push_back(grid_op_result(in_data));
      if (!in_valid || in_ready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_data <= op_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %p", $time, out_data);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("read_value", want.read_value, out_data.read_value);
          check_field("square_size", want.square_size, out_data.square_size);
          check_field("center_row", want.center_row, out_data.center_row);
          check_field("center_col", want.center_col, out_data.center_col);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_occupancy_grid_square_finder: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int ph_w     [NUM_PHASES] = '{8, 5, 16, 3, 1, 0, 5, 127, 64};
    int ph_h     [NUM_PHASES] = '{8, 7, 4, 3, 1, 5, 0, 127, 2};
    int ph_count [NUM_PHASES] = '{150, 150, 150, 120, 60, 40, 30, 150, 90};
    int ph_gap   [NUM_PHASES] = '{0, 87, 0, 11, 0, 87, 0, 0, 11};
    int ph_stall [NUM_PHASES] = '{0, 0, 87, 11, 0, 0, 87, 87, 11};
    int ph_query [NUM_PHASES] = '{15, 15, 15, 20, 25, 20, 20, 0, 10};
    int p, i, w, h;
    for (i = 0; i < GRID_MAX_W*GRID_MAX_H; i++) grid_cells[i] = 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on the reset 64x64 grid
    push_op(FUNC_QUERY, 0, 0, 0);
    push_op(FUNC_READ, 0, 0, 0);
    push_op(FUNC_WRITE, 63, 63, 255);
    push_op(FUNC_READ, 63, 63, 0);
    push_op(FUNC_WRITE, 64, 0, 8'hAA);
    push_op(FUNC_READ, 0, 64, 0);
    push_op(FUNC_READ, 255, 255, 0);
    push_op(FUNC_WRITE, 0, 255, 8'h55);
    push_op(FUNC_OBSTACLE, 63, 63, 0);
    push_op(FUNC_OBSTACLE, 255, 255, 0);
    push_op(FUNC_WRITE, 10, 10, 1);
    push_op(FUNC_OBSTACLE, 10, 10, 0);
    push_op(FUNC_OBSTACLE, 10, 10, 0);
    push_op(FUNC_READ, 10, 11, 0);
    push_op(FUNC_WRITE, 20, 20, 254);
    push_op(FUNC_OBSTACLE, 19, 19, 0);
    push_op(FUNC_OBSTACLE, 20, 20, 0);
    push_op(FUNC_READ, 20, 20, 0);
    push_op(FUNC_WRITE, 0, 0, 8'h80);
    push_op(FUNC_QUERY, 0, 0, 0);
    push_op(FUNC_WRITE, 63, 63, 0);
    push_op(FUNC_WRITE, 0, 0, 0);
    push_op(FUNC_OBSTACLE, 0, 0, 0);
    push_op(FUNC_READ, 1, 1, 0);
    push_op(FUNC_QUERY, 0, 0, 0);
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      set_grid_dims(7'(ph_w[p]), 7'(ph_h[p]));
      send_gap_pct = ph_gap[p];
      recv_stall_pct = ph_stall[p];
      w = (ph_w[p] > GRID_MAX_W) ? GRID_MAX_W : ph_w[p];
      h = (ph_h[p] > GRID_MAX_H) ? GRID_MAX_H : ph_h[p];
      // full-size grids: only an occasional query, each one walks every cell
      for (i = 0; i < ph_count[p]; i++)
        op_queue.push_back(random_op(w, h, ph_query[p],
                                     ph_query[p] == 0 && i % 50 == 49));
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_occupancy_grid_square_finder: PASS");
    else $display("tb_occupancy_grid_square_finder: FAIL");
    $finish;
  end

endmodule
